/* design/bcm_pkg.sv */
// Shared types, widths, register indexes and constant functions of the band cascade mixer.
package bcm_pkg;

  localparam int MAX_CASCADES_DEF = 16;

  localparam int MAG_W    = 32;
  localparam int WT_W     = 24;
  localparam int RATIO_W  = 48;
  localparam int USED_W   = 5;
  localparam int LOG_FRAC = 16;
  localparam int LOG_INT  = 6;
  localparam int LOG_W    = LOG_INT + LOG_FRAC;
  localparam int NUM_W    = 64;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W    = 48;

  localparam logic [RATIO_W-1:0] RATIO_MAX = {RATIO_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_MIN_WEIGHT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_FALLBACK = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_WEIGHT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LEVEL      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LEVEL_HARD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIX_MODE        = 3'd5;

  localparam logic [WT_W-1:0]    MIN_WEIGHT_RST      = 24'd6554;
  localparam logic [WT_W-1:0]    WEIGHT_FALLBACK_RST = 24'd65536;
  localparam logic [WT_W-1:0]    ZERO_WEIGHT_RST     = 24'd65536;
  localparam logic [RATIO_W-1:0] ZERO_LEVEL_RST      = 48'd338;
  localparam logic [RATIO_W-1:0] ZERO_LEVEL_HARD_RST = 48'd3;

  typedef logic [31:0] ctab_t [LOG_FRAC];

  // Bitwise integer square root, evaluated at elaboration only.
  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bit_r;
    v = v_in;
    res = '0;
    bit_r = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (bit_r > v) bit_r = bit_r >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bit_r != 0) begin
        if (v >= res + bit_r) begin
          v = v - (res + bit_r);
          res = (res >> 1) + bit_r;
        end else begin
          res = res >> 1;
        end
        bit_r = bit_r >> 2;
      end
    end
    return res;
  endfunction

  // Entry k holds 2^(2^-(k+1)) in Q1.31.
  function automatic ctab_t make_ctab();
    ctab_t t;
    logic [63:0] c;
    c = isqrt64(64'h8000_0000_0000_0000);
    for (int k = 0; k < LOG_FRAC; k++) begin
      t[k] = c[31:0];
      c = isqrt64(c << 31);
    end
    return t;
  endfunction

endpackage

/* design/bcm_ram.sv */
// Generic single-port-write, registered-read RAM.
module bcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

/* design/bcm_div.sv */
// Restoring radix-2 divider, one quotient bit per cycle.
module bcm_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [bcm_pkg::NUM_W-1:0]         num,
  input  logic [bcm_pkg::WT_W-1:0]          den,
  output logic                              done,
  output logic [bcm_pkg::NUM_W-1:0]         quo
);

  localparam int CW = $clog2(bcm_pkg::NUM_W + 1);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic [bcm_pkg::NUM_W-1:0]     q_r, q_nxt;
  logic [bcm_pkg::WT_W-1:0]      rem_r, rem_nxt;
  logic [bcm_pkg::WT_W-1:0]      den_r, den_nxt;
  logic [bcm_pkg::WT_W:0]        rem_sh;
  logic                          ge;

  assign rem_sh = {rem_r, q_r[bcm_pkg::NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt = ge ? bcm_pkg::WT_W'(rem_sh - {1'b0, den_r}) : rem_sh[bcm_pkg::WT_W-1:0];
      q_nxt   = {q_r[bcm_pkg::NUM_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(bcm_pkg::NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

/* design/bcm_log.sv */
// Iterative log2: normalizing shift, then one squaring per fraction bit.
module bcm_log (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [bcm_pkg::RATIO_W-1:0]   ratio,
  output logic                          done,
  output logic [bcm_pkg::LOG_W-1:0]     log_val
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_NORM = 2'd1;
  localparam logic [1:0] PH_SQ   = 2'd2;

  logic [1:0]                          ph_r, ph_nxt;
  logic                                done_r, done_nxt;
  logic [bcm_pkg::RATIO_W-1:0]         m48_r, m48_nxt;
  logic [bcm_pkg::LOG_INT-1:0]         e_r, e_nxt;
  logic [31:0]                         m_r, m_nxt;
  logic [3:0]                          k_r, k_nxt;
  logic [bcm_pkg::LOG_FRAC-1:0]        frac_r, frac_nxt;
  logic [63:0]                         prod;
  logic [32:0]                         sq;

  assign prod = 64'(m_r) * 64'(m_r);
  assign sq   = prod[63:31];

  always_comb begin
    ph_nxt   = ph_r;
    done_nxt = 1'b0;
    m48_nxt  = m48_r;
    e_nxt    = e_r;
    m_nxt    = m_r;
    k_nxt    = k_r;
    frac_nxt = frac_r;
    unique case (ph_r)
      PH_IDLE: begin
        if (start) begin
          m48_nxt = ratio;
          e_nxt   = bcm_pkg::LOG_INT'(bcm_pkg::RATIO_W - 1);
          ph_nxt  = PH_NORM;
        end
      end
      PH_NORM: begin
        if (m48_r[bcm_pkg::RATIO_W-1]) begin
          m_nxt  = m48_r[bcm_pkg::RATIO_W-1 -: 32];
          k_nxt  = '0;
          ph_nxt = PH_SQ;
        end else begin
          m48_nxt = {m48_r[bcm_pkg::RATIO_W-2:0], 1'b0};
          e_nxt   = e_r - 1'b1;
        end
      end
      PH_SQ: begin
        // A square of 2.0 or more yields a one bit and is halved back into range.
        m_nxt    = sq[32] ? sq[32:1] : sq[31:0];
        frac_nxt = {frac_r[bcm_pkg::LOG_FRAC-2:0], sq[32]};
        k_nxt    = k_r + 1'b1;
        if (k_r == 4'(bcm_pkg::LOG_FRAC - 1)) begin
          ph_nxt   = PH_IDLE;
          done_nxt = 1'b1;
        end
      end
      default: ph_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      done_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      done_r <= done_nxt;
    end
    m48_r  <= m48_nxt;
    e_r    <= e_nxt;
    m_r    <= m_nxt;
    k_r    <= k_nxt;
    frac_r <= frac_nxt;
  end

  assign done    = done_r;
  assign log_val = {e_r, frac_r};

endmodule

/* design/bcm_exp.sv */
// Iterative exp2 of a log2 value: one constant multiply per fraction bit, then a shift.
module bcm_exp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [bcm_pkg::LOG_W-1:0]     log_val,
  output logic                          done,
  output logic [bcm_pkg::RATIO_W-1:0]   value
);

  localparam bcm_pkg::ctab_t CTAB = bcm_pkg::make_ctab();

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_RUN   = 2'd1;
  localparam logic [1:0] PH_SHIFT = 2'd2;

  logic [1:0]                          ph_r, ph_nxt;
  logic                                done_r, done_nxt;
  logic [31:0]                         x_r, x_nxt;
  logic [bcm_pkg::LOG_INT-1:0]         ip_r, ip_nxt;
  logic [bcm_pkg::LOG_FRAC-1:0]        fp_r, fp_nxt;
  logic [3:0]                          k_r, k_nxt;
  logic [bcm_pkg::RATIO_W-1:0]         val_r, val_nxt;
  logic [63:0]                         prod;

  assign prod = 64'(x_r) * 64'(CTAB[k_r]);

  always_comb begin
    ph_nxt   = ph_r;
    done_nxt = 1'b0;
    x_nxt    = x_r;
    ip_nxt   = ip_r;
    fp_nxt   = fp_r;
    k_nxt    = k_r;
    val_nxt  = val_r;
    unique case (ph_r)
      PH_IDLE: begin
        if (start) begin
          x_nxt  = 32'h8000_0000;
          ip_nxt = log_val[bcm_pkg::LOG_W-1:bcm_pkg::LOG_FRAC];
          fp_nxt = log_val[bcm_pkg::LOG_FRAC-1:0];
          k_nxt  = '0;
          ph_nxt = PH_RUN;
        end
      end
      PH_RUN: begin
        if (fp_r[bcm_pkg::LOG_FRAC-1]) x_nxt = prod[62:31];
        fp_nxt = {fp_r[bcm_pkg::LOG_FRAC-2:0], 1'b0};
        k_nxt  = k_r + 1'b1;
        if (k_r == 4'(bcm_pkg::LOG_FRAC - 1)) ph_nxt = PH_SHIFT;
      end
      PH_SHIFT: begin
        if (ip_r > 6'd47) begin
          val_nxt = bcm_pkg::RATIO_MAX;
        end else if (ip_r >= 6'd31) begin
          val_nxt = bcm_pkg::RATIO_W'(x_r) << (ip_r - 6'd31);
        end else begin
          val_nxt = bcm_pkg::RATIO_W'(x_r >> (6'd31 - ip_r));
        end
        ph_nxt   = PH_IDLE;
        done_nxt = 1'b1;
      end
      default: ph_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      done_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      done_r <= done_nxt;
    end
    x_r   <= x_nxt;
    ip_r  <= ip_nxt;
    fp_r  <= fp_nxt;
    k_r   <= k_nxt;
    val_r <= val_nxt;
  end

  assign done  = done_r;
  assign value = val_r;

endmodule

/* design/band_cascade_mixer_core.sv */
// Top level of the band cascade mixer: cascade store, scan sequencer and output register.
//
//   channel | direction | beat contents
//   in_     | sink      | magnitude, band_weight, last_cascade
//   out_    | source    | band_value, cascades_used
//   cfg_    | sink      | index, data (register write)
//
// A non-closing beat is stored on acceptance. A closing beat starts a scan of the
// stored cascades: each cascade is read, then its ratio is formed on the divider
// (skipped for a zero weight) and, when it enters a geometric mean, its log in the log
// unit; at most two passes. The mean is then formed on the divider, and the geometric
// mean passes through the exp unit. Input is held off during a scan.
// Reset (synchronous, rst_n low) clears the count, control and registers only.
// The output register lets a new band be stored while a result waits for out_ready.
module band_cascade_mixer_core #(
  parameter int MAX_CASCADES = bcm_pkg::MAX_CASCADES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [bcm_pkg::MAG_W-1:0]          in_magnitude,
  input  logic [bcm_pkg::WT_W-1:0]           in_band_weight,
  input  logic                               in_last_cascade,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [bcm_pkg::RATIO_W-1:0]        out_band_value,
  output logic [bcm_pkg::USED_W-1:0]         out_cascades_used,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bcm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bcm_pkg::CFG_W-1:0]          cfg_data
);

  localparam int AW    = (MAX_CASCADES > 1) ? $clog2(MAX_CASCADES) : 1;
  localparam int CNT_W = $clog2(MAX_CASCADES + 1);
  localparam int WS_W  = bcm_pkg::WT_W + CNT_W;
  localparam int SUM_W = bcm_pkg::RATIO_W + CNT_W;
  localparam int LS_W  = bcm_pkg::LOG_W + CNT_W;
  localparam int RAM_W = bcm_pkg::WT_W + bcm_pkg::MAG_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_RW   = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_EVAL = 4'd4;
  localparam logic [3:0] S_LOG  = 4'd5;
  localparam logic [3:0] S_NEXT = 4'd6;
  localparam logic [3:0] S_ENDP = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;
  localparam logic [3:0] S_MDIV = 4'd9;
  localparam logic [3:0] S_EXP  = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  logic [3:0]                    state_r, state_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [CNT_W-1:0]              n_r, n_nxt;
  logic [CNT_W-1:0]              idx_r, idx_nxt;
  logic [CNT_W-1:0]              used_r, used_nxt;
  logic                          pass_r, pass_nxt;
  logic                          zero_r, zero_nxt;
  logic                          stop_r, stop_nxt;
  logic [WS_W-1:0]               wsum_r, wsum_nxt;
  logic [SUM_W-1:0]              sum_r, sum_nxt;
  logic [LS_W-1:0]               lsum_r, lsum_nxt;
  logic [bcm_pkg::RATIO_W-1:0]   ratio_r, ratio_nxt;
  logic [bcm_pkg::WT_W-1:0]      wt_r, wt_nxt;
  logic [bcm_pkg::RATIO_W-1:0]   res_r, res_nxt;

  logic [bcm_pkg::WT_W-1:0]      min_weight_r, weight_fallback_r, zero_weight_r;
  logic [bcm_pkg::RATIO_W-1:0]   zero_level_r, zero_level_hard_r;
  logic                          mix_mode_r;

  logic                          out_valid_r, out_valid_nxt;
  logic [bcm_pkg::RATIO_W-1:0]   out_val_r, out_val_nxt;
  logic [bcm_pkg::USED_W-1:0]    out_used_r, out_used_nxt;

  logic                          in_acc;
  logic                          room;
  logic                          ram_we, ram_re;
  logic [RAM_W-1:0]              ram_rd;
  logic [bcm_pkg::WT_W-1:0]      rd_wt;
  logic [bcm_pkg::MAG_W-1:0]     rd_mag;

  logic                          div_start, div_done;
  logic [bcm_pkg::NUM_W-1:0]     div_num, div_quo;
  logic [bcm_pkg::WT_W-1:0]      div_den;
  logic                          log_start, log_done;
  logic [bcm_pkg::LOG_W-1:0]     log_val;
  logic                          exp_start, exp_done;
  logic [bcm_pkg::RATIO_W-1:0]   exp_val;

  logic                          use_ok;
  logic [WS_W-1:0]               wsum_use;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign room      = cnt_r < CNT_W'(MAX_CASCADES);
  assign ram_we    = in_acc && room;
  assign ram_re    = (state_r == S_RD) && (idx_r != n_r);
  assign rd_wt     = ram_rd[RAM_W-1:bcm_pkg::MAG_W];
  assign rd_mag    = ram_rd[bcm_pkg::MAG_W-1:0];

  bcm_ram #(
    .WIDTH(RAM_W),
    .DEPTH(MAX_CASCADES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cnt_r[AW-1:0]),
    .wdata({in_band_weight, in_magnitude}),
    .re   (ram_re),
    .raddr(idx_r[AW-1:0]),
    .rdata(ram_rd)
  );

  bcm_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  bcm_log u_log (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (log_start),
    .ratio  (ratio_r),
    .done   (log_done),
    .log_val(log_val)
  );

  bcm_exp u_exp (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (exp_start),
    .log_val(div_quo[bcm_pkg::LOG_W-1:0]),
    .done   (exp_done),
    .value  (exp_val)
  );

  assign use_ok   = pass_r ? ((wt_r >= zero_weight_r) && (wt_r < min_weight_r))
                           : (wt_r >= min_weight_r);
  assign wsum_use = wsum_r + WS_W'(wt_r);

  always_comb begin
    if (state_r == S_RW) begin
      div_num = {16'b0, rd_mag, 16'b0};
      div_den = rd_wt;
    end else begin
      div_num = mix_mode_r ? bcm_pkg::NUM_W'(sum_r) : bcm_pkg::NUM_W'(lsum_r);
      div_den = bcm_pkg::WT_W'(used_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    idx_nxt   = idx_r;
    used_nxt  = used_r;
    pass_nxt  = pass_r;
    zero_nxt  = zero_r;
    stop_nxt  = stop_r;
    wsum_nxt  = wsum_r;
    sum_nxt   = sum_r;
    lsum_nxt  = lsum_r;
    ratio_nxt = ratio_r;
    wt_nxt    = wt_r;
    res_nxt   = res_r;
    div_start = 1'b0;
    log_start = 1'b0;
    exp_start = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_val_nxt   = out_val_r;
    out_used_nxt  = out_used_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          // A beat past a full store is dropped, but its flag still closes the band.
          cnt_nxt = room ? cnt_r + 1'b1 : cnt_r;
          if (in_last_cascade) begin
            n_nxt     = cnt_nxt;
            cnt_nxt   = '0;
            idx_nxt   = '0;
            used_nxt  = '0;
            pass_nxt  = 1'b0;
            zero_nxt  = 1'b0;
            wsum_nxt  = '0;
            sum_nxt   = '0;
            lsum_nxt  = '0;
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        state_nxt = (idx_r == n_r) ? S_ENDP : S_RW;
      end
      S_RW: begin
        wt_nxt = rd_wt;
        if (rd_wt == '0) begin
          ratio_nxt = bcm_pkg::RATIO_MAX;
          state_nxt = S_EVAL;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          ratio_nxt = div_quo[bcm_pkg::RATIO_W-1:0];
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (ratio_r < zero_level_hard_r) begin
          state_nxt = S_ENDP;
        end else if (!use_ok) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_RD;
        end else begin
          used_nxt  = used_r + 1'b1;
          wsum_nxt  = wsum_use;
          stop_nxt  = (ratio_r < zero_level_r) ||
                      (pass_r && (wsum_use >= WS_W'(weight_fallback_r)));
          state_nxt = S_NEXT;
          if (mix_mode_r) begin
            sum_nxt = sum_r + SUM_W'(ratio_r);
          end else if (ratio_r == '0) begin
            zero_nxt = 1'b1;
          end else begin
            log_start = 1'b1;
            state_nxt = S_LOG;
          end
        end
      end
      S_LOG: begin
        if (log_done) begin
          lsum_nxt  = lsum_r + LS_W'(log_val);
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        if (stop_r) begin
          state_nxt = S_ENDP;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_ENDP: begin
        if (!pass_r && (wsum_r < WS_W'(weight_fallback_r))) begin
          pass_nxt  = 1'b1;
          idx_nxt   = '0;
          state_nxt = S_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (used_r == '0 || (!mix_mode_r && zero_r)) begin
          res_nxt   = '0;
          state_nxt = S_OUT;
        end else begin
          div_start = 1'b1;
          state_nxt = S_MDIV;
        end
      end
      S_MDIV: begin
        if (div_done) begin
          if (mix_mode_r) begin
            res_nxt   = div_quo[bcm_pkg::RATIO_W-1:0];
            state_nxt = S_OUT;
          end else begin
            exp_start = 1'b1;
            state_nxt = S_EXP;
          end
        end
      end
      S_EXP: begin
        if (exp_done) begin
          res_nxt   = exp_val;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_r;
          out_used_nxt  = (used_r > CNT_W'(31)) ? 5'd31 : bcm_pkg::USED_W'(used_r);
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_IDLE;
      cnt_r             <= '0;
      out_valid_r       <= 1'b0;
      min_weight_r      <= bcm_pkg::MIN_WEIGHT_RST;
      weight_fallback_r <= bcm_pkg::WEIGHT_FALLBACK_RST;
      zero_weight_r     <= bcm_pkg::ZERO_WEIGHT_RST;
      zero_level_r      <= bcm_pkg::ZERO_LEVEL_RST;
      zero_level_hard_r <= bcm_pkg::ZERO_LEVEL_HARD_RST;
      mix_mode_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          bcm_pkg::REG_MIN_WEIGHT:      min_weight_r      <= cfg_data[bcm_pkg::WT_W-1:0];
          bcm_pkg::REG_WEIGHT_FALLBACK: weight_fallback_r <= cfg_data[bcm_pkg::WT_W-1:0];
          bcm_pkg::REG_ZERO_WEIGHT:     zero_weight_r     <= cfg_data[bcm_pkg::WT_W-1:0];
          bcm_pkg::REG_ZERO_LEVEL:      zero_level_r      <= cfg_data[bcm_pkg::RATIO_W-1:0];
          bcm_pkg::REG_ZERO_LEVEL_HARD: zero_level_hard_r <= cfg_data[bcm_pkg::RATIO_W-1:0];
          bcm_pkg::REG_MIX_MODE:        mix_mode_r        <= cfg_data[0];
          default: ;
        endcase
      end
    end
    n_r        <= n_nxt;
    idx_r      <= idx_nxt;
    used_r     <= used_nxt;
    pass_r     <= pass_nxt;
    zero_r     <= zero_nxt;
    stop_r     <= stop_nxt;
    wsum_r     <= wsum_nxt;
    sum_r      <= sum_nxt;
    lsum_r     <= lsum_nxt;
    ratio_r    <= ratio_nxt;
    wt_r       <= wt_nxt;
    res_r      <= res_nxt;
    out_val_r  <= out_val_nxt;
    out_used_r <= out_used_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_band_value    = out_val_r;
  assign out_cascades_used = out_used_r;

  // A closing beat starts a scan, so input is held off on the next cycle.
  a_close_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_cascade |=> !in_ready)
    else $error("input accepted right after a closing beat");

  // The store count never runs past the store depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_CASCADES))
    else $error("stored count exceeds store depth");

  // A scan never reads past the cascades stored for the band.
  a_read_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |-> idx_r < n_r)
    else $error("store read beyond the band's cascades");

  // The divider is only started when the sequencer is not already waiting on it.
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (state_r == S_RW || state_r == S_FIN))
    else $error("divider started from an unexpected state");

endmodule

/* tb/tb.sv */
// Self-checking testbench for band_cascade_mixer_core: directed table plus random bands.
`timescale 1ns / 1ps
module tb;

  localparam int MAX_CASCADES_DEF = bcm_pkg::MAX_CASCADES_DEF;
  localparam int MAG_W     = bcm_pkg::MAG_W;
  localparam int WT_W      = bcm_pkg::WT_W;
  localparam int RATIO_W   = bcm_pkg::RATIO_W;
  localparam int USED_W    = bcm_pkg::USED_W;
  localparam int LOG_FRAC  = bcm_pkg::LOG_FRAC;
  localparam int CFG_IDX_W = bcm_pkg::CFG_IDX_W;
  localparam int CFG_W     = bcm_pkg::CFG_W;
  localparam logic [RATIO_W-1:0] RATIO_MAX = bcm_pkg::RATIO_MAX;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_WEIGHT      = bcm_pkg::REG_MIN_WEIGHT;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_FALLBACK = bcm_pkg::REG_WEIGHT_FALLBACK;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_WEIGHT     = bcm_pkg::REG_ZERO_WEIGHT;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LEVEL      = bcm_pkg::REG_ZERO_LEVEL;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LEVEL_HARD = bcm_pkg::REG_ZERO_LEVEL_HARD;
  localparam logic [CFG_IDX_W-1:0] REG_MIX_MODE        = bcm_pkg::REG_MIX_MODE;

  localparam logic [WT_W-1:0]    MIN_WEIGHT_RST      = bcm_pkg::MIN_WEIGHT_RST;
  localparam logic [WT_W-1:0]    WEIGHT_FALLBACK_RST = bcm_pkg::WEIGHT_FALLBACK_RST;
  localparam logic [WT_W-1:0]    ZERO_WEIGHT_RST     = bcm_pkg::ZERO_WEIGHT_RST;
  localparam logic [RATIO_W-1:0] ZERO_LEVEL_RST      = bcm_pkg::ZERO_LEVEL_RST;
  localparam logic [RATIO_W-1:0] ZERO_LEVEL_HARD_RST = bcm_pkg::ZERO_LEVEL_HARD_RST;

  localparam int NCAS = MAX_CASCADES_DEF;
  localparam int WATCHDOG_LIMIT = 200000;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic [WT_W-1:0]  wt;
    logic             last;
  } cascade_beat_t;

  typedef struct packed {
    logic [RATIO_W-1:0] value;
    logic [USED_W-1:0]  used;
  } band_result_t;

  typedef struct packed {
    cascade_beat_t      beat;
    logic               has_exp;
    logic [RATIO_W-1:0] exp_value;
    logic [USED_W-1:0]  exp_used;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [MAG_W-1:0] in_magnitude = '0;
  logic [WT_W-1:0] in_band_weight = '0;
  logic in_last_cascade = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [RATIO_W-1:0] out_band_value;
  logic [USED_W-1:0] out_cascades_used;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  band_cascade_mixer_core dut (.*);

  // Mirror of the block's registers and cascade store.
  logic [WT_W-1:0]    m_min_weight, m_weight_fallback, m_zero_weight;
  logic [RATIO_W-1:0] m_zero_level, m_zero_level_hard;
  logic               m_mix_mode;
  logic [MAG_W-1:0]   m_mag_store [NCAS];
  logic [WT_W-1:0]    m_wt_store [NCAS];
  int                 m_count;
  logic [63:0]        exp_ctab [LOG_FRAC];

  band_result_t pending_results [$];
  table_row_t   dir_rows [$];
  int errors = 0;
  int bands_closed = 0;
  int beats_sent = 0;
  int results_seen = 0;
  bit stim_done = 0;
  bit hold_off = 0;

  function automatic logic [63:0] sqrt_floor(input logic [63:0] v_in);
    logic [63:0] v, res, b;
    v = v_in;
    res = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] ratio_of(input logic [MAG_W-1:0] mag, input logic [WT_W-1:0] wt);
    if (wt == 0) return {16'h0, RATIO_MAX};
    return ({32'h0, mag} << 16) / wt;
  endfunction

  function automatic logic [63:0] log2_q16(input logic [63:0] r);
    int e;
    logic [63:0] t, m, frac;
    e = 0;
    t = r;
    frac = 0;
    while (t > 1) begin
      t = t >> 1;
      e++;
    end
    m = (e >= 31) ? (r >> (e - 31)) : (r << (31 - e));
    for (int i = 0; i < LOG_FRAC; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >> 32) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return (64'(e) << LOG_FRAC) | frac;
  endfunction

  function automatic logic [63:0] exp2_q16(input logic [63:0] l);
    logic [63:0] ip, fp, x, v;
    ip = l >> LOG_FRAC;
    fp = l & 64'hFFFF;
    x = 64'h8000_0000;
    for (int k = 1; k <= LOG_FRAC; k++)
      if ((fp >> (LOG_FRAC - k)) & 1) x = (x * exp_ctab[k-1]) >> 31;
    if (ip > 47) return {16'h0, RATIO_MAX};
    v = (ip >= 31) ? (x << (ip - 31)) : (x >> (31 - ip));
    return (v > {16'h0, RATIO_MAX}) ? {16'h0, RATIO_MAX} : v;
  endfunction

  // Stores one cascade; on a closing beat, mixes the band and returns its result.
  function automatic bit mix_band(input cascade_beat_t b, output band_result_t res);
    int n, used;
    logic [63:0] wsum, sum, logsum, r, w, val;
    bit zero_seen;
    if (m_count < NCAS) begin
      m_mag_store[m_count] = b.mag;
      m_wt_store[m_count] = b.wt;
      m_count++;
    end
    if (!b.last) return 0;
    n = m_count;
    m_count = 0;
    used = 0;
    wsum = 0;
    sum = 0;
    logsum = 0;
    zero_seen = 0;
    for (int pass = 0; pass < 2; pass++) begin
      if (pass == 1 && wsum >= m_weight_fallback) break;
      for (int i = 0; i < n; i++) begin
        w = m_wt_store[i];
        r = ratio_of(m_mag_store[i], m_wt_store[i]);
        if (r < m_zero_level_hard) break;
        if (pass == 0) begin
          if (w < m_min_weight) continue;
        end else if (w < m_zero_weight || w >= m_min_weight) begin
          continue;
        end
        if (m_mix_mode) sum += r;
        else if (r == 0) zero_seen = 1;
        else logsum += log2_q16(r);
        wsum += w;
        used++;
        if (r < m_zero_level) break;
        if (pass == 1 && wsum >= m_weight_fallback) break;
      end
    end
    if (used == 0) val = 0;
    else if (m_mix_mode) val = sum / used;
    else if (zero_seen) val = 0;
    else val = exp2_q16(logsum / used);
    res.value = (val > {16'h0, RATIO_MAX}) ? RATIO_MAX : val[RATIO_W-1:0];
    res.used = (used > 31) ? 5'd31 : USED_W'(used);
    return 1;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MIN_WEIGHT:      m_min_weight = val[WT_W-1:0];
      REG_WEIGHT_FALLBACK: m_weight_fallback = val[WT_W-1:0];
      REG_ZERO_WEIGHT:     m_zero_weight = val[WT_W-1:0];
      REG_ZERO_LEVEL:      m_zero_level = val[RATIO_W-1:0];
      REG_ZERO_LEVEL_HARD: m_zero_level_hard = val[RATIO_W-1:0];
      REG_MIX_MODE:        m_mix_mode = val[0];
      default: ;
    endcase
  endtask

  // Drives one beat and holds it until accepted; the beat is predicted at acceptance.
  task automatic send_beat(input cascade_beat_t b);
    band_result_t r;
    in_magnitude <= b.mag;
    in_band_weight <= b.wt;
    in_last_cascade <= b.last;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
    if (mix_band(b, r)) begin
      pending_results.push_back(r);
      bands_closed++;
    end
  endtask

  task automatic idle_gap();
    int g;
    g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Waits until the block has delivered everything, then lets any scan settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [WT_W-1:0] pick_weight();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return {WT_W{1'b1}};
      2: return WT_W'($urandom_range(1, 6553));
      3: return WT_W'($urandom_range(6554, 65535));
      4: return WT_W'($urandom);
      default: return WT_W'($urandom_range(30000, 200000));
    endcase
  endfunction

  function automatic logic [MAG_W-1:0] pick_mag();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return MAG_W'($urandom_range(0, 40));
      default: return $urandom;
    endcase
  endfunction

  task automatic random_band(input int ncas);
    cascade_beat_t b;
    for (int i = 0; i < ncas; i++) begin
      b.mag = pick_mag();
      b.wt = pick_weight();
      b.last = (i == ncas - 1);
      send_beat(b);
      if ($urandom_range(0, 1) == 0) idle_gap();
    end
  endtask

  task automatic add_row(input logic [MAG_W-1:0] mag, input logic [WT_W-1:0] wt,
                         input logic last, input logic has_exp,
                         input logic [RATIO_W-1:0] ev, input logic [USED_W-1:0] eu);
    table_row_t row;
    row.beat.mag = mag;
    row.beat.wt = wt;
    row.beat.last = last;
    row.has_exp = has_exp;
    row.exp_value = ev;
    row.exp_used = eu;
    dir_rows.push_back(row);
  endtask

  // Receiver: stalls on its own pattern and for long stretches while hold_off is set.
  initial begin
    int phase;
    phase = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      phase++;
      if (hold_off) out_ready <= 1'b0;
      else if ((phase % 64) < 24) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 2) != 0);
    end
  end

  always @(posedge clk) begin
    band_result_t e;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result value=%h used=%0d", $time, out_band_value,
                 out_cascades_used);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (e.value !== out_band_value) begin
          $display("%0t band_value expected %h actual %h", $time, e.value, out_band_value);
          errors++;
        end
        if (e.used !== out_cascades_used) begin
          $display("%0t cascades_used expected %0d actual %0d", $time, e.used,
                   out_cascades_used);
          errors++;
        end
      end
    end
  end

  // Watchdog over cycles in which no beat moves on any channel.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) || !rst_n)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("band_cascade_mixer_core: mismatch");
      $finish;
    end
  end

  initial begin
    logic [63:0] c;
    band_result_t dummy;
    table_row_t row;
    c = sqrt_floor(64'h8000_0000_0000_0000);
    for (int k = 0; k < LOG_FRAC; k++) begin
      exp_ctab[k] = c;
      c = sqrt_floor(c << 31);
    end
    m_min_weight = MIN_WEIGHT_RST;
    m_weight_fallback = WEIGHT_FALLBACK_RST;
    m_zero_weight = ZERO_WEIGHT_RST;
    m_zero_level = ZERO_LEVEL_RST;
    m_zero_level_hard = ZERO_LEVEL_HARD_RST;
    m_mix_mode = 1'b0;
    m_count = 0;

    // Directed rows: reset settings, geometric mean.
    add_row(32'h8000_0000, 24'h01_0000, 1'b1, 1'b1, 48'h0000_8000_0000, 5'd1);
    add_row(32'h1234_5678, 24'd0, 1'b1, 1'b1, 48'd0, 5'd0);
    add_row(32'd0, 24'd100, 1'b1, 1'b1, 48'd0, 5'd0);
    add_row(32'hFFFF_FFFF, 24'hFF_FFFF, 1'b1, 1'b0, 0, 0);
    add_row(32'h4000_0000, 24'h00_8000, 1'b0, 1'b0, 0, 0);
    add_row(32'h0000_0100, 24'h02_0000, 1'b0, 1'b0, 0, 0);
    add_row(32'h0100_0000, 24'h00_0100, 1'b1, 1'b0, 0, 0);
    add_row(32'h7000_0000, 24'd5000, 1'b1, 1'b1, 48'd0, 5'd0);
    for (int i = 0; i < 18; i++)
      add_row(32'h1000_0000 + i, 24'h01_0000 + i, i == 17, 1'b0, 0, 0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_beat(row.beat);
      if (row.has_exp) pending_results[pending_results.size()-1] = {row.exp_value, row.exp_used};
      idle_gap();
    end
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_MIX_MODE, 1);
        end
        1: begin
          write_reg(REG_MIN_WEIGHT, 0);
          write_reg(REG_ZERO_LEVEL_HARD, 0);
        end
        2: begin
          write_reg(REG_MIX_MODE, 0);
          write_reg(REG_MIN_WEIGHT, 24'hFF_FFFF);
          write_reg(REG_WEIGHT_FALLBACK, 24'hFF_FFFF);
          write_reg(REG_ZERO_WEIGHT, 0);
          write_reg(REG_ZERO_LEVEL, 0);
        end
        3: begin
          write_reg(REG_MIN_WEIGHT, 24'd40000);
          write_reg(REG_WEIGHT_FALLBACK, 24'd300000);
          write_reg(REG_ZERO_WEIGHT, 24'd1000);
          write_reg(REG_ZERO_LEVEL, 48'h0000_1000_0000);
          write_reg(REG_ZERO_LEVEL_HARD, 48'd200);
        end
        4: begin
          write_reg(REG_MIX_MODE, 1);
          write_reg(REG_ZERO_LEVEL, RATIO_MAX);
          write_reg(REG_ZERO_LEVEL_HARD, RATIO_MAX);
        end
        5: begin
          write_reg(REG_ZERO_LEVEL_HARD, 0);
          write_reg(REG_ZERO_LEVEL, 48'h0001_0000_0000);
          write_reg(REG_WEIGHT_FALLBACK, 0);
        end
        6: begin
          write_reg(REG_MIX_MODE, 0);
          write_reg(REG_MIN_WEIGHT, MIN_WEIGHT_RST);
          write_reg(REG_WEIGHT_FALLBACK, WEIGHT_FALLBACK_RST);
          write_reg(REG_ZERO_WEIGHT, 24'd100);
          write_reg(REG_ZERO_LEVEL, ZERO_LEVEL_RST);
          write_reg(REG_ZERO_LEVEL_HARD, ZERO_LEVEL_HARD_RST);
        end
        default: begin
          write_reg(REG_MIX_MODE, 1);
        end
      endcase
      while (beats_sent < 25 + (ph + 1) * 210) begin
        // Mostly short bands; a few fill or overflow the store.
        random_band(($urandom_range(0, 15) == 0) ? $urandom_range(16, 19)
                                                : $urandom_range(1, 6));
        if (ph == 3 && beats_sent > 25 + 3 * 210 + 100 && hold_off == 0) begin
          hold_off = 1;
          fork
            begin
              repeat (3000) @(posedge clk);
              hold_off = 0;
            end
          join_none
        end
      end
      drain();
    end
    stim_done = 1;

    $display("Sent %0d cascade beats closing %0d bands; %0d results checked.",
             beats_sent, bands_closed, results_seen);
    $display("Both mean modes and the threshold extremes were exercised.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("band_cascade_mixer_core: match");
    end else begin
      $display("band_cascade_mixer_core: mismatch");
    end
    $finish;
  end

endmodule
